/* rtl/wtcw_pkg.sv */
// shared types and constants for the windowed text console writer
package wtcw_pkg;

  localparam int unsigned ScreenCols = 80;
  localparam int unsigned ScreenRows = 25;
  localparam int unsigned NumCells   = ScreenCols * ScreenRows;
  localparam int unsigned AddrW      = $clog2(NumCells);
  localparam int unsigned ColW       = 7;
  localparam int unsigned RowW       = 5;

  localparam logic [ColW-1:0] Win2Start = ColW'(ScreenCols / 2 - 1);
  localparam logic [ColW-1:0] Win1Last  = ColW'(ScreenCols / 2 - 3);
  localparam logic [ColW-1:0] Win2Last  = ColW'(ScreenCols / 2 - 1 + ScreenCols / 2 - 1);
  localparam logic [ColW-1:0] Win0Last  = ColW'(ScreenCols - 1);
  localparam logic [ColW-1:0] DivCol    = ColW'(ScreenCols / 2 - 2);
  localparam logic [RowW-1:0] RowsVal   = RowW'(ScreenRows);
  localparam logic [RowW-1:0] LastRow   = RowW'(ScreenRows - 1);

  localparam logic [7:0] ChBackspace = 8'd8;
  localparam logic [7:0] ChTab       = 8'd9;
  localparam logic [7:0] ChNewline   = 8'd10;
  localparam logic [7:0] ChSpace     = 8'd32;
  localparam logic [7:0] ChDivider   = 8'd219;
  localparam logic [7:0] AttrBlank   = 8'h0F;
  localparam logic [7:0] AttrPad     = 8'h07;

  localparam logic [2:0] ReqPut    = 3'd0;
  localparam logic [2:0] ReqRead   = 3'd1;
  localparam logic [2:0] ReqSelect = 3'd2;
  localparam logic [2:0] ReqHome   = 3'd3;
  localparam logic [2:0] ReqDual   = 3'd4;
  localparam logic [2:0] ReqSingle = 3'd5;

  typedef struct packed {
    logic [2:0] req_type;
    logic [7:0] char_code;
    logic [3:0] fg_color;
    logic [3:0] bg_color;
    logic       advance;
    logic [1:0] window_sel;
    logic [4:0] read_row;
    logic [6:0] read_col;
  } req_t;

  typedef struct packed {
    logic [7:0] cell_char;
    logic [7:0] cell_attr;
    logic [6:0] cursor_col;
    logic [4:0] cursor_row;
    logic [1:0] active_win;
  } rsp_t;

endpackage

/* rtl/windowed_text_console_writer.sv */
// windowed text console writer top level: screen memory, cursors and sequencer
// One request is taken at a time; ready stays low until its result has been
// taken on the output side. The screen memory has one write and one registered
// read port and all work goes through it. After reset a clearing pass zeroes
// every cell of the memory before the first request is taken. A select, cursor
// reset, single layout or unused code goes from decode straight to the result;
// a read first waits for the registered memory data. Dual layout rewrites the
// divider column with one read-modify-write per row. A plain character writes
// one cell; a backspace blanks one cell (and writes nothing at the window's
// first column of row 0). Tab and newline write one cell per cycle, unless the
// second tab space waits for a scroll (newline pads up to the window's last
// column). A deferred scroll copies each cell of the window up one row, reading
// it and then writing it, and then blanks the bottom row. The output register
// holds a finished result while the input side sits idle.
module windowed_text_console_writer (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  wtcw_pkg::req_t       in_data_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output wtcw_pkg::rsp_t       out_data_o
);
  import wtcw_pkg::*;

  typedef enum logic [3:0] {
    StClear, StIdle, StDecode, StReadWait, StBsp, StWrite, StScrRd, StScrWr,
    StBlank, StDivRd, StDivWr, StDone
  } state_e;

  // what StWrite does after each cell: single cell, tab pair or newline pad
  typedef enum logic [1:0] { WrSingle, WrTab, WrNewline } wrmode_e;

  state_e              state_q;
  wrmode_e             wrmode_q;
  req_t                req_q;
  logic [ColW-1:0]     ccol_q [3];
  logic [RowW-1:0]     crow_q [3];
  logic [1:0]          win_q;
  logic [AddrW-1:0]    clr_q;
  logic [RowW-1:0]     srow_q;   // destination row of the scroll walk
  logic [ColW-1:0]     scol_q;
  logic                tab2_q;
  logic [7:0]          rd_char_q, rd_attr_q;
  rsp_t                rsp_q;
  logic                out_valid_q;

  // screen memory
  logic [15:0]         mem [NumCells];
  logic                we;
  logic [AddrW-1:0]    waddr, raddr;
  logic [15:0]         wdata, rdata_q;

  always_ff @(posedge clk_i) begin
    if (we) mem[waddr] <= wdata;
    rdata_q <= mem[raddr];
  end

  // cell address: row times the screen width, plus the column
  function automatic logic [AddrW-1:0] cell_addr(logic [RowW-1:0] r, logic [ColW-1:0] c);
    logic [AddrW-1:0] rr;
    rr = AddrW'(r);
    return AddrW'(rr * AddrW'(ScreenCols)) + AddrW'(c);
  endfunction

  // current window geometry
  logic [1:0]      w;
  logic [ColW-1:0] wstart, wlast, cc;
  logic [RowW-1:0] cr;
  assign w      = win_q;
  assign wstart = (w == 2'd2) ? Win2Start : '0;
  assign wlast  = (w == 2'd2) ? Win2Last : (w == 2'd1) ? Win1Last : Win0Last;
  assign cc     = ccol_q[w];
  assign cr     = crow_q[w];

  logic [7:0] attr_in;
  assign attr_in = {req_q.bg_color, req_q.fg_color};

  // cell written by StWrite
  logic [7:0] wr_char, wr_attr;
  always_comb begin
    unique case (wrmode_q)
      WrNewline: begin wr_char = ChSpace; wr_attr = AttrPad; end
      WrTab:     begin wr_char = ChSpace; wr_attr = attr_in; end
      default:   begin wr_char = req_q.char_code; wr_attr = attr_in; end
    endcase
  end

  logic rd_in_range;
  assign rd_in_range = (req_q.read_row < RowsVal) && (req_q.read_col < ColW'(ScreenCols));

  always_comb begin
    we    = 1'b0;
    waddr = '0;
    wdata = '0;
    raddr = '0;
    unique case (state_q)
      StClear: begin we = 1'b1; waddr = clr_q; end
      StDecode: raddr = cell_addr(req_q.read_row, req_q.read_col);
      StBsp: begin we = 1'b1; waddr = cell_addr(cr, cc); wdata = {AttrBlank, ChSpace}; end
      StWrite: begin we = 1'b1; waddr = cell_addr(cr, cc); wdata = {wr_attr, wr_char}; end
      StScrRd: raddr = cell_addr(srow_q + RowW'(1), scol_q);
      StScrWr: begin we = 1'b1; waddr = cell_addr(srow_q, scol_q); wdata = rdata_q; end
      StBlank: begin we = 1'b1; waddr = cell_addr(LastRow, scol_q); wdata = {8'h00, ChSpace}; end
      StDivRd: raddr = cell_addr(srow_q, DivCol);
      StDivWr: begin
        we = 1'b1; waddr = cell_addr(srow_q, DivCol); wdata = {rdata_q[15:8], ChDivider};
      end
      default: ;
    endcase
  end

  logic at_last;
  assign at_last = (cc == wlast);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StClear;
      wrmode_q    <= WrSingle;
      clr_q       <= '0;
      ccol_q[0]   <= '0;
      ccol_q[1]   <= '0;
      ccol_q[2]   <= Win2Start;
      crow_q[0]   <= '0;
      crow_q[1]   <= '0;
      crow_q[2]   <= '0;
      win_q       <= '0;
      srow_q      <= '0;
      scol_q      <= '0;
      tab2_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (out_valid_q && out_ready_i) out_valid_q <= 1'b0;
      unique case (state_q)
        StClear: begin
          clr_q <= clr_q + AddrW'(1);
          if (clr_q == AddrW'(NumCells - 1)) state_q <= StIdle;
        end
        StIdle: begin
          if (in_valid_i && !out_valid_q) begin
            req_q   <= in_data_i;
            state_q <= StDecode;
          end
        end
        StDecode: begin
          rd_char_q <= '0;
          rd_attr_q <= '0;
          unique case (req_q.req_type)
            ReqPut: begin
              if (req_q.char_code == ChBackspace) begin
                if (cc != wstart) begin
                  ccol_q[w] <= cc - ColW'(1);
                  state_q   <= StBsp;
                end else if (cr != '0) begin
                  crow_q[w] <= cr - RowW'(1);
                  ccol_q[w] <= wlast;
                  state_q   <= StBsp;
                end else begin
                  state_q   <= StDone;
                end
              end else begin
                wrmode_q <= (req_q.char_code == ChNewline) ? WrNewline :
                            (req_q.char_code == ChTab) ? WrTab : WrSingle;
                tab2_q   <= 1'b0;
                if (cr == RowsVal) begin
                  // pending scroll: walk the window up one row first
                  srow_q  <= '0;
                  scol_q  <= wstart;
                  state_q <= StScrRd;
                end else begin
                  state_q <= StWrite;
                end
              end
            end
            ReqRead: state_q <= StReadWait;
            ReqSelect: begin
              if (req_q.window_sel != 2'd3) win_q <= req_q.window_sel;
              state_q <= StDone;
            end
            ReqHome: begin ccol_q[w] <= wstart; crow_q[w] <= '0; state_q <= StDone; end
            ReqDual: begin
              ccol_q[1] <= '0; crow_q[1] <= '0;
              ccol_q[2] <= Win2Start; crow_q[2] <= '0;
              win_q     <= 2'd1;
              srow_q    <= '0;
              state_q   <= StDivRd;
            end
            ReqSingle: begin
              win_q <= 2'd0; ccol_q[0] <= '0; crow_q[0] <= '0; state_q <= StDone;
            end
            default: state_q <= StDone;
          endcase
        end
        StReadWait: begin
          if (rd_in_range) begin
            rd_char_q <= rdata_q[7:0];
            rd_attr_q <= rdata_q[15:8];
          end
          state_q <= StDone;
        end
        StBsp: state_q <= StDone;
        StScrRd: state_q <= StScrWr;
        StScrWr: begin
          if (scol_q == wlast) begin
            scol_q <= wstart;
            if (srow_q == RowW'(ScreenRows - 2)) state_q <= StBlank;
            else begin srow_q <= srow_q + RowW'(1); state_q <= StScrRd; end
          end else begin
            scol_q  <= scol_q + ColW'(1);
            state_q <= StScrRd;
          end
        end
        StBlank: begin
          if (scol_q == wlast) begin
            crow_q[w] <= cr - RowW'(1);
            state_q   <= StWrite;
          end else scol_q <= scol_q + ColW'(1);
        end
        StWrite: begin
          if (wrmode_q != WrSingle || req_q.advance) begin
            if (at_last) begin
              ccol_q[w] <= wstart;
              crow_q[w] <= cr + RowW'(1);
            end else ccol_q[w] <= cc + ColW'(1);
          end
          if (wrmode_q == WrTab && !tab2_q) begin
            tab2_q <= 1'b1;
            // second space may itself need a scroll
            if (at_last && cr == LastRow) begin
              srow_q <= '0; scol_q <= wstart; state_q <= StScrRd;
            end else state_q <= StWrite;
          end else if (wrmode_q == WrNewline && !at_last) begin
            state_q <= StWrite;
          end else begin
            state_q <= StDone;
          end
        end
        StDivRd: state_q <= StDivWr;
        StDivWr: begin
          if (srow_q == LastRow) state_q <= StDone;
          else begin srow_q <= srow_q + RowW'(1); state_q <= StDivRd; end
        end
        StDone: begin
          rsp_q.cell_char  <= rd_char_q;
          rsp_q.cell_attr  <= rd_attr_q;
          rsp_q.cursor_col <= cc;
          rsp_q.cursor_row <= cr;
          rsp_q.active_win <= win_q;
          out_valid_q      <= 1'b1;
          state_q          <= StIdle;
        end
        default: state_q <= StIdle;
      endcase
    end
  end

  assign in_ready_o  = (state_q == StIdle) && !out_valid_q;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = rsp_q;

endmodule

/* rtl/wtcw_checker.sv */
// port-level checks for the windowed text console writer
module wtcw_checker (
  input logic           clk_i,
  input logic           rst_ni,
  input logic           in_valid_i,
  input logic           in_ready_o,
  input logic           out_valid_o,
  input logic           out_ready_i,
  input wtcw_pkg::rsp_t out_data_o
);
  import wtcw_pkg::*;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("result changed while stalled");

  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("second request taken while busy");

  a_win_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_data_o.active_win != 2'd3)
    else $error("window out of range");

  a_row_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_data_o.cursor_row <= RowsVal)
    else $error("cursor row out of range");

endmodule

bind windowed_text_console_writer wtcw_checker u_wtcw_checker (
  .clk_i(clk_i), .rst_ni(rst_ni), .in_valid_i(in_valid_i), .in_ready_o(in_ready_o),
  .out_valid_o(out_valid_o), .out_ready_i(out_ready_i), .out_data_o(out_data_o)
);
